>>> rtl/core/tmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace buffer package
// Shared types, constants and codes of the memory access trace buffer.
// ----------------------------------------------------------------------------
package tmb_pkg;

    localparam int TRACE_DEPTH = 16;
    localparam int TRACE_AW    = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
    localparam int TRACE_CW    = $clog2(TRACE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DUMP   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_FIND_MISS,
        S_DUMP_RD,
        S_DUMP_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] pc;
        logic [31:0] addr;
        logic [63:0] data;
        logic [3:0]  len;
        logic        is_write;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [31:0] entry_pc;
        logic [31:0] entry_addr;
        logic [63:0] entry_data;
        logic [3:0]  entry_len;
        logic        entry_write;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] addr;
        logic [63:0] data;
        logic [3:0]  len;
        logic        write;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // result load request from the sequencer to the output register
    typedef struct packed {
        logic load;
        logic found;
        logic last;
    } t_emit;

endpackage

>>> rtl/core/memory_access_trace_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory access trace buffer
// Ring of the most recent memory accesses with record, find and read-out.
// ----------------------------------------------------------------------------
// A record transfer is accepted without a stall and the next transfer may
// follow at once; instruction fetches (reads whose address equals the pc) are
// dropped. Find walks from newest to oldest through the trace memory (one
// read port, one write port), reading and then comparing each examined entry,
// and returns one result.
// Read-out returns every stored entry oldest first, reading and then emitting
// each one, with last set on the final one; an empty buffer returns nothing.
// Input is stalled while a find or read-out is in progress. No clearing pass
// is needed after reset.
module memory_access_trace_buffer import tmb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic                r_out_valid;
    t_out_item           r_out;
    logic                out_free;
    logic                wr_en;
    logic [TRACE_AW-1:0] wr_addr;
    logic                rd_en;
    logic [TRACE_AW-1:0] rd_addr;
    logic [ENTRY_W-1:0]  rd_raw;
    t_entry              rd_entry;
    t_entry              wr_entry;
    t_emit               emit;

    assign out_free = !r_out_valid || !i_out_stall;

    assign wr_entry.pc    = i_in.pc;
    assign wr_entry.addr  = i_in.addr;
    assign wr_entry.data  = i_in.data;
    assign wr_entry.len   = i_in.len;
    assign wr_entry.write = i_in.is_write;
    assign rd_entry       = t_entry'(rd_raw);

    tmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_out_free (out_free),
        .i_rd_pc    (rd_entry.pc),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_emit     (emit)
    );

    tmb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TRACE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (ENTRY_W'(wr_entry)),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_out.found <= emit.found;
            r_out.last  <= emit.last;
            if (emit.found) begin
                r_out.entry_pc    <= rd_entry.pc;
                r_out.entry_addr  <= rd_entry.addr;
                r_out.entry_data  <= rd_entry.data;
                r_out.entry_len   <= rd_entry.len;
                r_out.entry_write <= rd_entry.write;
            end else begin
                r_out.entry_pc    <= '0;
                r_out.entry_addr  <= '0;
                r_out.entry_data  <= '0;
                r_out.entry_len   <= '0;
                r_out.entry_write <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/core/tmb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/tmb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace buffer sequencer
// Ring pointers, fill count and the walk over the entries for find and
// read-out commands.
// ----------------------------------------------------------------------------
module tmb_ctrl import tmb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in,
    input  logic                i_out_free,
    input  logic [31:0]         i_rd_pc,
    output logic                o_wr_en,
    output logic [TRACE_AW-1:0] o_wr_addr,
    output logic                o_rd_en,
    output logic [TRACE_AW-1:0] o_rd_addr,
    output t_emit               o_emit
);

    localparam int SW = TRACE_CW + 1;

    t_state              r_state, n_state;
    logic [TRACE_AW-1:0] r_wp, n_wp;
    logic [TRACE_CW-1:0] r_cnt, n_cnt;
    logic [TRACE_AW-1:0] r_slot, n_slot;
    logic [TRACE_CW-1:0] r_left, n_left;
    logic [31:0]         r_query, n_query;

    logic                accept;
    logic                is_fetch;
    logic                hit;
    logic                last_one;
    logic [TRACE_AW-1:0] slot_dec;
    logic [TRACE_AW-1:0] slot_inc;
    logic [TRACE_AW-1:0] wp_dec;
    logic [TRACE_AW-1:0] wp_inc;
    logic [SW-1:0]       wp_ext;
    logic [SW-1:0]       cnt_ext;
    logic [TRACE_AW-1:0] first;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign is_fetch = !i_in.is_write && (i_in.addr == i_in.pc);
    assign hit      = (i_rd_pc == r_query);
    assign last_one = (r_left == TRACE_CW'(1));

    assign slot_dec = (r_slot == '0) ? TRACE_AW'(TRACE_DEPTH - 1) : r_slot - 1'b1;
    assign slot_inc = (r_slot == TRACE_AW'(TRACE_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign wp_dec   = (r_wp == '0) ? TRACE_AW'(TRACE_DEPTH - 1) : r_wp - 1'b1;
    assign wp_inc   = (r_wp == TRACE_AW'(TRACE_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    // oldest slot: write pointer minus fill count, modulo depth
    assign wp_ext  = SW'(r_wp);
    assign cnt_ext = SW'(r_cnt);
    assign first   = (wp_ext >= cnt_ext) ? TRACE_AW'(wp_ext - cnt_ext)
                                         : TRACE_AW'(wp_ext + SW'(TRACE_DEPTH) - cnt_ext);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.command)
                        CMD_FIND: n_state = (r_cnt == '0) ? S_FIND_MISS : S_FIND_RD;
                        CMD_DUMP: n_state = (r_cnt == '0) ? S_IDLE : S_DUMP_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_FIND_RD: n_state = S_FIND_CMP;
            S_FIND_CMP: begin
                if (hit) begin
                    if (i_out_free) n_state = S_IDLE;
                end else if (last_one) begin
                    n_state = S_FIND_MISS;
                end else begin
                    n_state = S_FIND_RD;
                end
            end
            S_FIND_MISS: begin
                if (i_out_free) n_state = S_IDLE;
            end
            S_DUMP_RD: n_state = S_DUMP_EMIT;
            S_DUMP_EMIT: begin
                if (i_out_free) n_state = last_one ? S_IDLE : S_DUMP_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        o_wr_en      = accept && (i_in.command == CMD_RECORD) && !is_fetch;
        o_wr_addr    = r_wp;
        o_rd_en      = (r_state == S_FIND_RD) || (r_state == S_DUMP_RD);
        o_rd_addr    = r_slot;
        o_emit       = '0;
        unique case (r_state)
            S_FIND_CMP: begin
                o_emit.load  = hit && i_out_free;
                o_emit.found = 1'b1;
                o_emit.last  = 1'b1;
            end
            S_FIND_MISS: begin
                o_emit.load  = i_out_free;
                o_emit.found = 1'b0;
                o_emit.last  = 1'b1;
            end
            S_DUMP_EMIT: begin
                o_emit.load  = i_out_free;
                o_emit.found = 1'b1;
                o_emit.last  = last_one;
            end
            default: o_emit = '0;
        endcase
    end

    // pointers and walk counters
    always_comb begin
        n_wp    = r_wp;
        n_cnt   = r_cnt;
        n_slot  = r_slot;
        n_left  = r_left;
        n_query = r_query;
        if (accept) begin
            case (i_in.command)
                CMD_RECORD: begin
                    if (!is_fetch) begin
                        n_wp = wp_inc;
                        if (r_cnt != TRACE_CW'(TRACE_DEPTH)) n_cnt = r_cnt + 1'b1;
                    end
                end
                CMD_FIND: begin
                    n_query = i_in.pc;
                    n_slot  = wp_dec;
                    n_left  = r_cnt;
                end
                CMD_DUMP: begin
                    n_slot = first;
                    n_left = r_cnt;
                end
                default: n_wp = r_wp;
            endcase
        end else if (r_state == S_FIND_CMP && !hit) begin
            n_slot = slot_dec;
            n_left = r_left - 1'b1;
        end else if (r_state == S_DUMP_EMIT && i_out_free) begin
            n_slot = slot_inc;
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_cnt   <= '0;
            r_slot  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_cnt   <= n_cnt;
            r_slot  <= n_slot;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query <= n_query;
    end

endmodule

>>> rtl/core/tmb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace buffer checker
// Port-level properties of the trace buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tmb_checker import tmb_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.found |->
            o_out.last && (o_out.entry_pc == '0) && (o_out.entry_addr == '0) &&
            (o_out.entry_data == '0) && (o_out.entry_len == '0) &&
            !o_out.entry_write)
        else $error("miss result not all zero");

    a_mid_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> o_out.found)
        else $error("read-out row without entry");

    a_record_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.command == CMD_RECORD) |=> !o_in_stall)
        else $error("record blocked the next transfer");

endmodule

bind memory_access_trace_buffer tmb_checker u_tmb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace buffer testbench
// Sends record, find, read-out and unused-command transfers with random gaps on both sides.
// A scoreboard keeps its own copy of the ring and checks every result
// transfer, in order, against the rows it predicts.
// ----------------------------------------------------------------------------
module tb_top;
    import tmb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 183;
    localparam int MAX_REPORTS  = 10;

    class trace_scoreboard;
        t_entry      ring [TRACE_DEPTH];
        int unsigned wr_slot;
        int unsigned valid_cnt;
        t_out_item   pending_rows [$];
        int unsigned errors;

        function new();
            wr_slot   = 0;
            valid_cnt = 0;
            errors    = 0;
        endfunction

        function t_out_item entry_row(int unsigned slot, bit is_last);
            t_out_item row;
            row.found       = 1'b1;
            row.entry_pc    = ring[slot].pc;
            row.entry_addr  = ring[slot].addr;
            row.entry_data  = ring[slot].data;
            row.entry_len   = ring[slot].len;
            row.entry_write = ring[slot].write;
            row.last        = is_last;
            return row;
        endfunction

        function void note_input(t_in_item item);
            t_out_item   row;
            int unsigned slot;
            int unsigned first;
            bit          hit;
            case (item.command)
                CMD_RECORD: begin
                    // reads at addr == pc are instruction fetches
                    if (item.is_write || item.addr != item.pc) begin
                        ring[wr_slot] = '{item.pc, item.addr, item.data, item.len,
                                          item.is_write};
                        wr_slot = (wr_slot + 1) % TRACE_DEPTH;
                        if (valid_cnt < TRACE_DEPTH)
                            valid_cnt++;
                    end
                end
                CMD_FIND: begin
                    row      = '0;
                    row.last = 1'b1;
                    hit      = 1'b0;
                    for (int i = 0; i < valid_cnt && !hit; i++) begin
                        slot = (wr_slot + TRACE_DEPTH - 1 - i) % TRACE_DEPTH;
                        if (ring[slot].pc == item.pc) begin
                            row = entry_row(slot, 1'b1);
                            hit = 1'b1;
                        end
                    end
                    pending_rows.push_back(row);
                end
                CMD_DUMP: begin
                    first = (wr_slot + TRACE_DEPTH - valid_cnt) % TRACE_DEPTH;
                    for (int i = 0; i < valid_cnt; i++)
                        pending_rows.push_back(entry_row((first + i) % TRACE_DEPTH,
                                                         i + 1 == valid_cnt));
                end
                default: ;
            endcase
        endfunction

        function void report(string what, t_out_item want, t_out_item got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s: expected found=%0b pc=%h addr=%h data=%h len=%0d wr=%0b last=%0b",
                         what, want.found, want.entry_pc, want.entry_addr,
                         want.entry_data, want.entry_len, want.entry_write, want.last,
                         "\n    got      found=%0b pc=%h addr=%h data=%h len=%0d wr=%0b last=%0b",
                         got.found, got.entry_pc, got.entry_addr, got.entry_data,
                         got.entry_len, got.entry_write, got.last);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_rows.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = pending_rows.pop_front();
            if (got.found !== want.found || got.entry_pc !== want.entry_pc ||
                got.entry_addr !== want.entry_addr || got.entry_data !== want.entry_data ||
                got.entry_len !== want.entry_len || got.entry_write !== want.entry_write ||
                got.last !== want.last)
                report("mismatch", want, got);
        endfunction

        function void close();
            if (pending_rows.size() != 0) begin
                $display("%0d expected results never arrived", pending_rows.size());
                errors += pending_rows.size();
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    trace_scoreboard sb;
    bit          idle_on    = 1'b1;
    int unsigned stall_left = 0;
    int unsigned cycles     = 0;
    logic [31:0] pc_pool [8];

    memory_access_trace_buffer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check each transfer, then stall at random while gaps are on
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                sb.check_result(out_item);
                stall_left = idle_on ? $urandom_range(0, 3) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    function automatic t_in_item access(logic [1:0] cmd, logic [31:0] pc, logic [31:0] addr,
                                        logic [63:0] data, logic [3:0] len, logic wr);
        t_in_item item;
        item.command  = cmd;
        item.pc       = pc;
        item.addr     = addr;
        item.data     = data;
        item.len      = len;
        item.is_write = wr;
        return item;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item    item;
        int unsigned pick;
        pick          = $urandom_range(0, 99);
        item.pc       = ($urandom_range(0, 1) != 0) ? pc_pool[$urandom_range(0, 7)]
                                                     : $urandom();
        item.addr     = $urandom();
        item.data     = {$urandom(), $urandom()};
        item.len      = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
        item.is_write = 1'($urandom_range(0, 1));
        if (pick < 65) begin
            item.command = CMD_RECORD;
            if ($urandom_range(0, 6) == 0)
                item.addr = item.pc;
        end else if (pick < 85) begin
            item.command = CMD_FIND;
        end else if (pick < 95) begin
            item.command = CMD_DUMP;
        end else begin
            item.command = CMD_UNUSED;
        end
        return item;
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(item);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rows.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        int       sent;
        sb = new();
        pc_pool[0] = '0;
        pc_pool[7] = '1;
        for (int i = 1; i < 7; i++)
            pc_pool[i] = $urandom();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty buffer, fetch drop, field extremes, duplicates, wrap
        send_item(access(CMD_DUMP, '0, '0, '0, 4'd0, 1'b0));
        send_item(access(CMD_FIND, '0, '0, '0, 4'd0, 1'b0));
        send_item(access(CMD_RECORD, 32'h1000, 32'h1000, 64'h1234, 4'd4, 1'b0));
        send_item(access(CMD_RECORD, '0, '0, '0, 4'd0, 1'b1));
        send_item(access(CMD_RECORD, '1, '0, '1, 4'd8, 1'b0));
        send_item(access(CMD_RECORD, 32'h10, '1, {16{4'h5}}, 4'd15, 1'b1));
        send_item(access(CMD_RECORD, 32'h10, 32'h20, {16{4'hA}}, 4'd9, 1'b0));
        send_item(access(CMD_FIND, 32'h10, '1, '1, 4'd15, 1'b1));
        send_item(access(CMD_FIND, '0, '0, '0, 4'd0, 1'b0));
        send_item(access(CMD_FIND, 32'h1000, '0, '0, 4'd0, 1'b0));
        send_item(access(CMD_DUMP, '1, '1, '1, 4'd15, 1'b1));
        send_item(access(CMD_UNUSED, 32'h10, '0, '0, 4'd0, 1'b0));
        for (int i = 0; i < 13; i++)
            send_item(access(CMD_RECORD, $urandom() | 32'h1, $urandom(),
                             {$urandom(), $urandom()}, 4'($urandom_range(0, 15)), 1'b1));
        send_item(access(CMD_FIND, '0, '0, '0, 4'd0, 1'b0));
        send_item(access(CMD_DUMP, '0, '0, '0, 4'd0, 1'b0));
        wait_drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on <= ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(10, 40)) begin
                if (sent < RANDOM_ITEMS) begin
                    send_item(rand_item());
                    sent++;
                end
            end
            if ($urandom_range(0, 2) == 0)
                wait_drain();
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
